>>> sv/tzpc_pkg.sv
// Package: payload words, constants and event codes of the two-zone people counter.
`timescale 1ns / 1ps
`default_nettype none
package tzpc_pkg;

  localparam logic [15:0] THRESHOLD_RESET = 16'd1780;
  localparam logic [14:0] COUNT_MAX       = 15'h7fff;
  localparam int          PATH_DEPTH      = 4;
  localparam int          FILL_W          = 3;

  localparam logic [FILL_W-1:0] FILL_START = FILL_W'(1);
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(PATH_DEPTH);

  // occupancy patterns: bit 0 left, bit 1 right
  localparam logic [1:0] PAT_NONE  = 2'd0;
  localparam logic [1:0] PAT_LEFT  = 2'd1;
  localparam logic [1:0] PAT_RIGHT = 2'd2;
  localparam logic [1:0] PAT_BOTH  = 2'd3;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ENTRY = 2'd1;
  localparam logic [1:0] EV_EXIT  = 2'd2;

  typedef struct packed {
    logic [15:0] distance_mm;
    logic        zone_sel;
  } in_word_t;

  typedef struct packed {
    logic [14:0] people_total;
    logic [1:0]  passing_event;
    logic        underflow_error;
  } out_word_t;

  // input stage to tracker
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } stage_t;

endpackage
`default_nettype wire

>>> sv/tzpc_in_stage.sv
// Input register stage with valid/stall handshake.
`timescale 1ns / 1ps
`default_nettype none
module tzpc_in_stage
  import tzpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_data,
  input  wire logic     advance,
  output stage_t        stage
);

  logic     valid_r, valid_nxt;
  in_word_t word_r;

  assign in_stall  = valid_r && !advance;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      word_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.word  = word_r;

endmodule
`default_nettype wire

>>> sv/tzpc_tracker.sv
// Zone occupancy, path history and people count; result of the current word.
`timescale 1ns / 1ps
`default_nettype none
module tzpc_tracker
  import tzpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire in_word_t    word,
  input  wire logic [15:0] threshold,
  output out_word_t        result
);

  logic              left_r, left_nxt;
  logic              right_r, right_nxt;
  logic [1:0]        hist_r [1:3];
  logic [1:0]        hist_nxt [1:3];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [14:0]       count_r, count_nxt;
  logic              err_r, err_nxt;

  logic              now_occ;
  logic              change;
  logic [1:0]        pattern;
  logic [FILL_W-1:0] fill_inc;
  logic [1:0]        passing;

  always_comb begin
    now_occ  = word.distance_mm < threshold;
    change   = word.zone_sel ? (now_occ != right_r) : (now_occ != left_r);
    left_nxt  = (!word.zone_sel && change) ? now_occ : left_r;
    right_nxt = (word.zone_sel && change) ? now_occ : right_r;
    pattern  = {right_nxt, left_nxt};
    fill_inc = (fill_r < FILL_FULL) ? fill_r + FILL_W'(1) : fill_r;

    hist_nxt  = hist_r;
    fill_nxt  = fill_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    passing   = EV_NONE;

    if (change) begin
      if (pattern == PAT_NONE) begin
        // both zones clear: check for a complete crossing
        if (fill_inc == FILL_FULL) begin
          if (hist_r[1] == PAT_LEFT && hist_r[2] == PAT_BOTH && hist_r[3] == PAT_RIGHT) begin
            passing = EV_ENTRY;
            if (count_r != COUNT_MAX) count_nxt = count_r + 15'd1;
          end else if (hist_r[1] == PAT_RIGHT && hist_r[2] == PAT_BOTH &&
                       hist_r[3] == PAT_LEFT) begin
            passing = EV_EXIT;
            if (count_r == 15'd0) err_nxt = 1'b1;
            else                  count_nxt = count_r - 15'd1;
          end
        end
        fill_nxt = FILL_START;
      end else begin
        fill_nxt = fill_inc;
        // slot fill_inc-1; a full path keeps overwriting the last slot
        case (fill_inc)
          FILL_W'(2): hist_nxt[1] = pattern;
          FILL_W'(3): hist_nxt[2] = pattern;
          default:    hist_nxt[3] = pattern;
        endcase
      end
    end

    result.people_total    = count_nxt;
    result.passing_event   = passing;
    result.underflow_error = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r    <= 1'b0;
      right_r   <= 1'b0;
      hist_r[1] <= PAT_NONE;
      hist_r[2] <= PAT_NONE;
      hist_r[3] <= PAT_NONE;
      fill_r    <= FILL_START;
      count_r   <= 15'd0;
      err_r     <= 1'b0;
    end else if (step) begin
      left_r    <= left_nxt;
      right_r   <= right_nxt;
      hist_r    <= hist_nxt;
      fill_r    <= fill_nxt;
      count_r   <= count_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/two_zone_people_counter.sv
// Top level of the two-zone people counter: config register, stages, result register.
//
//   channel  direction  handshake          word
//   in_      input      in_valid/in_stall   in_word_t  (distance_mm, zone_sel)
//   out_     output     out_valid/out_stall out_word_t (people_total, passing_event,
//                                                      underflow_error)
//   cfg_     input      cfg_valid/cfg_ready occupied_threshold, 16 bit
//
// One word per cycle while the output is not stalled; the edge that accepts a word
// loads the input register, and the result register loads from it when the output
// can advance, so out_valid rises as the result register loads. Tracker state updates
// in the same cycle as the result register loads, so the next word sees it directly.
// Synchronous active-low reset clears all control and tracker state and loads
// the threshold with 1780. A stalled output freezes both stages; in_stall rises
// only while the input register holds a word that cannot move on.
`timescale 1ns / 1ps
`default_nettype none
module two_zone_people_counter
  import tzpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic        cfg_we;
  logic [15:0] threshold_r;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r;
  out_word_t   result;
  stage_t      stage;
  logic        advance;
  logic        step;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold_r <= cfg_data;
    end
  end

  assign advance = !out_valid_r || !out_stall;
  assign step    = stage.valid && advance;

  tzpc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .stage    (stage)
  );

  tzpc_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .word      (stage.word),
    .threshold (threshold_r),
    .result    (result)
  );

  assign out_valid_nxt = advance ? stage.valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // the input register only holds back while it has a word
  a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (stage.valid && out_valid_r && out_stall))
    else $error("in_stall without a blocked word");

  // error flag is sticky across delivered results
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.underflow_error) |=>
      (!out_valid_r || out_data_r.underflow_error))
    else $error("underflow flag cleared");

  // an entry always leaves a nonzero count
  a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.passing_event == EV_ENTRY) |->
      (out_data_r.people_total != 15'd0))
    else $error("entry with zero count");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Testbench for the two-zone people counter: directed and random samples, checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  import tzpc_pkg::*;

  localparam logic ZONE_LEFT  = 1'b0;
  localparam logic ZONE_RIGHT = 1'b1;
  localparam int   CYCLE_LIMIT = 50000;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = THRESHOLD_RESET;

  two_zone_people_counter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [15:0] thr_q   = THRESHOLD_RESET;
  logic        left_q  = 1'b0;
  logic        right_q = 1'b0;
  logic [1:0]  path_q [PATH_DEPTH] = '{default: PAT_NONE};
  logic [FILL_W-1:0] fill_q = FILL_START;
  logic [14:0] count_q = '0;
  logic        err_q   = 1'b0;

  in_word_t  pending[$];
  out_word_t reports[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        queued = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  logic      hold_req = 1'b0;
  logic      calm = 1'b0;
  logic [15:0] gen_thr = THRESHOLD_RESET;

  function automatic out_word_t track_sample(in_word_t w);
    logic       now;
    logic       changed;
    logic [1:0] pat;
    out_word_t  r;
    now = w.distance_mm < thr_q;
    changed = 1'b0;
    r.passing_event = EV_NONE;
    if (w.zone_sel == ZONE_LEFT) begin
      if (now != left_q) begin
        changed = 1'b1;
        left_q = now;
      end
    end else begin
      if (now != right_q) begin
        changed = 1'b1;
        right_q = now;
      end
    end
    if (changed) begin
      pat = {right_q, left_q};
      if (fill_q < FILL_FULL) fill_q = fill_q + 1'b1;
      if (pat == PAT_NONE) begin
        if (fill_q == FILL_FULL) begin
          if (path_q[1] == PAT_LEFT && path_q[2] == PAT_BOTH && path_q[3] == PAT_RIGHT) begin
            r.passing_event = EV_ENTRY;
            if (count_q != COUNT_MAX) count_q = count_q + 1'b1;
          end else if (path_q[1] == PAT_RIGHT && path_q[2] == PAT_BOTH &&
                       path_q[3] == PAT_LEFT) begin
            r.passing_event = EV_EXIT;
            if (count_q == '0) err_q = 1'b1;
            else count_q = count_q - 1'b1;
          end
        end
        fill_q = FILL_START;
      end else begin
        // at a full path the last slot is overwritten
        path_q[2'(fill_q - 1'b1)] = pat;
      end
    end
    r.people_total    = count_q;
    r.underflow_error = err_q;
    return r;
  endfunction

  // sender
  always @(posedge clk) begin : sender
    logic     v;
    in_word_t d;
    v = in_valid;
    d = in_data;
    if (!rst_n) begin
      v = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reports.push_back(track_sample(in_data));
        v = 1'b0;
      end
      if (!v) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 4) - 1;
        end else if (pending.size() != 0) begin
          d = pending.pop_front();
          v = 1'b1;
        end
      end
    end
    in_valid <= v;
    in_data  <= d;
  end

  // receiver
  always @(posedge clk) begin : receiver
    logic nxt;
    nxt = 1'b0;
    if (rst_n) begin
      if (hold_req) begin
        hold_left = 48;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        nxt = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        nxt = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        nxt = 1'b1;
      end
    end
    out_stall <= nxt;
  end

  // result monitor
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reports.size() == 0) begin
        $error("result word with no prediction pending: %p", out_data);
        mismatches++;
      end else begin
        want = reports.pop_front();
        if (out_data.people_total !== want.people_total) begin
          $error("people_total: expected %0d, got %0d", want.people_total, out_data.people_total);
          mismatches++;
        end
        if (out_data.passing_event !== want.passing_event) begin
          $error("passing_event: expected %0d, got %0d",
                 want.passing_event, out_data.passing_event);
          mismatches++;
        end
        if (out_data.underflow_error !== want.underflow_error) begin
          $error("underflow_error: expected %0d, got %0d",
                 want.underflow_error, out_data.underflow_error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("two_zone_people_counter: mismatch");
      $finish;
    end
  end

  task automatic push_raw(logic zone, int mm);
    in_word_t w;
    w.distance_mm = mm[15:0];
    w.zone_sel    = zone;
    pending.push_back(w);
    queued++;
  endtask

  // distance that reads as occupied or free under the phase threshold
  task automatic push_reading(logic zone, logic occ);
    int mm;
    if (occ && gen_thr != 0) mm = $urandom_range(gen_thr - 1, 0);
    else mm = $urandom_range(65535, gen_thr);
    push_raw(zone, mm);
  endtask

  task automatic push_pass(logic is_entry, logic allow_repeats);
    logic first;
    logic lo;
    logic ro;
    logic z;
    first = is_entry ? ZONE_LEFT : ZONE_RIGHT;
    lo = 1'b0;
    ro = 1'b0;
    for (int s = 0; s < 4; s++) begin
      z = (s % 2 == 0) ? first : ~first;
      if (z == ZONE_LEFT) lo = (s < 2);
      else ro = (s < 2);
      push_reading(z, s < 2);
      // same-state readings between steps cause no event
      if (allow_repeats && $urandom_range(0, 3) == 0) begin
        z = 1'($urandom_range(0, 1));
        push_reading(z, z == ZONE_LEFT ? lo : ro);
      end
    end
  endtask

  task automatic add_random(int n);
    int target;
    int r;
    int k;
    target = queued + n;
    while (queued < target) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        push_reading(ZONE_LEFT, 1'b0);
        push_reading(ZONE_RIGHT, 1'b0);
        push_pass(1'($urandom_range(0, 1)), 1'b1);
      end else if (r < 8) begin
        k = $urandom_range(2, 6);
        repeat (k) push_reading(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        push_raw(1'($urandom_range(0, 1)), $urandom_range(65535, 0));
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || reports.size() != 0);
  endtask

  task automatic write_threshold(logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_q = v;
    gen_thr = v;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // exit with nobody inside: underflow
    push_raw(ZONE_RIGHT, 0);
    push_raw(ZONE_LEFT, 1779);
    push_raw(ZONE_RIGHT, 1780);
    push_raw(ZONE_LEFT, 65535);
    // entry with a no-event sample in the middle
    push_raw(ZONE_LEFT, 0);
    push_raw(ZONE_LEFT, 5);
    push_raw(ZONE_RIGHT, 100);
    push_raw(ZONE_LEFT, 2000);
    push_raw(ZONE_RIGHT, 1780);
    // plain exit
    push_raw(ZONE_RIGHT, 1);
    push_raw(ZONE_LEFT, 1);
    push_raw(ZONE_RIGHT, 3000);
    push_raw(ZONE_LEFT, 3000);
    // short path: both empty before the path is full
    push_raw(ZONE_LEFT, 10);
    push_raw(ZONE_LEFT, 65535);
    // 1,3,1,3,2: last slot overwritten, still an entry
    push_raw(ZONE_LEFT, 0);
    push_raw(ZONE_RIGHT, 0);
    push_raw(ZONE_RIGHT, 9999);
    push_raw(ZONE_RIGHT, 0);
    push_raw(ZONE_LEFT, 9999);
    push_raw(ZONE_RIGHT, 9999);
    // full path that matches neither direction
    push_raw(ZONE_RIGHT, 0);
    push_raw(ZONE_LEFT, 0);
    push_raw(ZONE_LEFT, 9999);
    push_raw(ZONE_RIGHT, 9999);
    drain();

    write_threshold(16'hffff);
    add_random(200);
    hold_req = 1'b1;
    drain();

    write_threshold(16'h0000);
    add_random(60);
    drain();

    write_threshold(16'h0001);
    add_random(100);
    drain();

    write_threshold(16'($urandom_range(65535, 0)));
    add_random(400);
    drain();

    calm = 1'b1;
    write_threshold(THRESHOLD_RESET);
    add_random(350);
    // a run of entries, a few exits, then more entries
    push_reading(ZONE_LEFT, 1'b0);
    push_reading(ZONE_RIGHT, 1'b0);
    repeat (8) push_pass(1'b1, 1'b0);
    repeat (3) push_pass(1'b0, 1'b0);
    repeat (4) push_pass(1'b1, 1'b0);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && reports.size() == 0) begin
      $display("two_zone_people_counter: match");
    end else begin
      $display("two_zone_people_counter: mismatch");
    end
    $finish;
  end

endmodule
